// ===== hw/rtl/ising_pkg.sv =====
// ----------------------------------------------------------------------------
// ising_pkg
// Shared constants, codes and helpers for the Metropolis spin-flip engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ising_pkg;

  // Lattice geometry
  localparam int LATTICE_SIDE = 64;
  localparam int IDX_W        = (LATTICE_SIDE > 1) ? $clog2(LATTICE_SIDE) : 1;
  localparam int SITE_COUNT   = LATTICE_SIDE * LATTICE_SIDE;

  // Field widths
  localparam int IN_IDX_W = 6;
  localparam int UNI_W    = 32;
  localparam int THR_W    = 33;
  localparam int DE_W     = 6;
  localparam int ENERGY_W = 15;
  localparam int MAGNET_W = 14;
  localparam int ACC_W    = 32;

  // Totals after reset: all spins up
  localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITE_COUNT);
  localparam logic [MAGNET_W-1:0] MAGNET_RESET = MAGNET_W'(SITE_COUNT);

  // Item kinds
  localparam logic KIND_FLIP = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Configuration register indexes
  localparam logic CFG_THR_DE4 = 1'b0;
  localparam logic CFG_THR_DE8 = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD0,
    S_RD1,
    S_EXEC
  } state_t;

  // Reduce an input coordinate to the lattice range (small constant table)
  function automatic logic [IDX_W-1:0] mod_side(input logic [IN_IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << IN_IDX_W); i++) begin
      if (v == IN_IDX_W'(i)) begin
        r = IDX_W'(i % LATTICE_SIDE);
      end
    end
    return r;
  endfunction

  // Wrapped neighbor indexes
  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] v);
    return (v == '0) ? IDX_W'(LATTICE_SIDE - 1) : v - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] v);
    return (v == IDX_W'(LATTICE_SIDE - 1)) ? '0 : v + IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ising_metropolis_spin_flip.sv =====
// ----------------------------------------------------------------------------
// ising_metropolis_spin_flip
// Metropolis single-spin-flip engine on a wrapped square lattice, with
// running energy, magnetization and a saturating acceptance counter.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------------
//  in      | in_valid / in_stall    | kind, row, col, uniform, spin_value, counted
//  out     | out_valid / out_stall  | flipped, spin_now, energy_change,
//          |                        | energy_total, magnet_total, accept_count
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  An item passes these steps in order: accept, read rows r and r-1 on the two
//  memory read ports, read row r+1, then evaluate and write row r back. The
//  row memory's read ports set these steps; a full output register holds the
//  item in its evaluate step. After reset the lattice is filled with up spins,
//  one row per cycle over all LATTICE_SIDE rows, while in_stall stays high.
//  The result register holds while out_stall is high; the next item is
//  taken meanwhile and waits in its evaluate step.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_spin_flip (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input item
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                kind,
  input  wire logic [ising_pkg::IN_IDX_W-1:0]      row,
  input  wire logic [ising_pkg::IN_IDX_W-1:0]      col,
  input  wire logic [ising_pkg::UNI_W-1:0]         uniform,
  input  wire logic                                spin_value,
  input  wire logic                                counted,
  // result item
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     flipped,
  output logic                                     spin_now,
  output logic signed [ising_pkg::DE_W-1:0]        energy_change,
  output logic signed [ising_pkg::ENERGY_W-1:0]    energy_total,
  output logic signed [ising_pkg::MAGNET_W-1:0]    magnet_total,
  output logic [ising_pkg::ACC_W-1:0]              accept_count,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_index,
  input  wire logic [ising_pkg::THR_W-1:0]         cfg_data
);

  localparam int SIDE  = ising_pkg::LATTICE_SIDE;
  localparam int IDX_W = ising_pkg::IDX_W;
  localparam int DE_W  = ising_pkg::DE_W;
  localparam int EN_W  = ising_pkg::ENERGY_W;
  localparam int MG_W  = ising_pkg::MAGNET_W;
  localparam int ACC_W = ising_pkg::ACC_W;

  // Row memory: one word per lattice row, one bit per site (1 = up)
  logic [SIDE-1:0]  spin_mem [SIDE];
  logic [SIDE-1:0]  rd_a_data;
  logic [SIDE-1:0]  rd_b_data;
  logic             rd_a_en;
  logic             rd_b_en;
  logic [IDX_W-1:0] rd_a_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [SIDE-1:0]  wr_data;

  // Sequencer
  ising_pkg::state_t state;
  ising_pkg::state_t state_next;
  logic [IDX_W-1:0]  clr_cnt;
  logic              exec_go;

  // Item registers
  logic                          kind_q;
  logic [ising_pkg::UNI_W-1:0]   uni_q;
  logic                          want_q;
  logic                          counted_q;
  logic [IDX_W-1:0]              row_q;
  logic [IDX_W-1:0]              row_m;
  logic [IDX_W-1:0]              row_p;
  logic [IDX_W-1:0]              col_q;
  logic [IDX_W-1:0]              col_m;
  logic [IDX_W-1:0]              col_p;
  logic [SIDE-1:0]               row_c;

  // Thresholds
  logic [ising_pkg::THR_W-1:0]   thr_de4;
  logic [ising_pkg::THR_W-1:0]   thr_de8;

  // Running totals
  logic signed [EN_W-1:0]        energy_reg;
  logic signed [MG_W-1:0]        magnet_reg;
  logic [ACC_W-1:0]              accept_reg;

  // Evaluate step
  logic                          s_old;
  logic [2:0]                    n_up;
  logic signed [DE_W-1:0]        quad;
  logic signed [DE_W-1:0]        de_up;
  logic signed [DE_W-1:0]        de_c;
  logic                          flip;
  logic [SIDE-1:0]               row_new;

  // --------------------------------------------------------------------------
  // Row memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      spin_mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_data <= spin_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_data <= spin_mem[row_m];
    end
  end

  // --------------------------------------------------------------------------
  // Energy change from the site and its four wrapped neighbors
  always_comb begin
    s_old = row_c[col_q];
    n_up  = 3'(row_c[col_m]) + 3'(row_c[col_p]) + 3'(rd_a_data[col_q])
          + 3'(rd_b_data[col_q]);
    quad  = $signed({1'b0, n_up, 2'b00});
    de_up = quad - DE_W'(8);
    de_c  = s_old ? de_up : -de_up;
    if (kind_q == ising_pkg::KIND_FLIP) begin
      flip = de_c[DE_W-1] || (de_c == '0)
          || ((de_c == DE_W'(4)) && ({1'b0, uni_q} <= thr_de4))
          || ((de_c == DE_W'(8)) && ({1'b0, uni_q} <= thr_de8));
    end else begin
      flip = (want_q != s_old);
    end
    row_new        = row_c;
    row_new[col_q] = ~s_old;
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state and memory controls
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    rd_a_en    = 1'b0;
    rd_b_en    = 1'b0;
    rd_a_addr  = row_q;
    wr_en      = 1'b0;
    wr_addr    = row_q;
    wr_data    = row_new;
    exec_go    = 1'b0;
    unique case (state)
      ising_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
        wr_data = '1;
        if (clr_cnt == IDX_W'(SIDE - 1)) begin
          state_next = ising_pkg::S_IDLE;
        end
      end
      ising_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ising_pkg::S_RD0;
        end
      end
      ising_pkg::S_RD0: begin
        rd_a_en    = 1'b1;
        rd_b_en    = 1'b1;
        state_next = ising_pkg::S_RD1;
      end
      ising_pkg::S_RD1: begin
        rd_a_en    = 1'b1;
        rd_a_addr  = row_p;
        state_next = ising_pkg::S_EXEC;
      end
      ising_pkg::S_EXEC: begin
        if (!out_valid || !out_stall) begin
          exec_go    = 1'b1;
          wr_en      = flip;
          state_next = ising_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ising_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ising_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ising_pkg::S_CLEAR) begin
        clr_cnt <= clr_cnt + IDX_W'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item capture at the input transfer
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_q    <= kind;
      uni_q     <= uniform;
      want_q    <= spin_value;
      counted_q <= counted;
      row_q     <= ising_pkg::mod_side(row);
      row_m     <= ising_pkg::wrap_dec(ising_pkg::mod_side(row));
      row_p     <= ising_pkg::wrap_inc(ising_pkg::mod_side(row));
      col_q     <= ising_pkg::mod_side(col);
      col_m     <= ising_pkg::wrap_dec(ising_pkg::mod_side(col));
      col_p     <= ising_pkg::wrap_inc(ising_pkg::mod_side(col));
    end
    // center row arrives in the cycle after its read
    if (state == ising_pkg::S_RD1) begin
      row_c <= rd_a_data;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_de4 <= '0;
      thr_de8 <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ising_pkg::CFG_THR_DE4: thr_de4 <= cfg_data;
        ising_pkg::CFG_THR_DE8: thr_de8 <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_reg <= ising_pkg::ENERGY_RESET;
      magnet_reg <= ising_pkg::MAGNET_RESET;
      accept_reg <= '0;
      out_valid  <= 1'b0;
    end else if (exec_go) begin
      out_valid <= 1'b1;
      if (flip) begin
        energy_reg <= energy_reg + {{(EN_W - DE_W){de_c[DE_W-1]}}, de_c};
        magnet_reg <= s_old ? magnet_reg - MG_W'(2) : magnet_reg + MG_W'(2);
        if ((kind_q == ising_pkg::KIND_FLIP) && counted_q && (accept_reg != '1)) begin
          accept_reg <= accept_reg + ACC_W'(1);
        end
      end
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      flipped       <= flip;
      spin_now      <= flip ? ~s_old : s_old;
      energy_change <= flip ? de_c : '0;
    end
  end

  // Totals only move when a result is loaded, so they track the result
  assign energy_total = energy_reg;
  assign magnet_total = magnet_reg;
  assign accept_count = accept_reg;

endmodule

`default_nettype wire
